// ===== hw/rtl/cpm_pkg.sv =====
// Shared types and constants for the capture period rate meter.
package cpm_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int STAMP_W = 16;
   localparam int PERIOD_W = 16;
   localparam int WORD_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int SHIFT_W = 4;

   localparam logic [WORD_W-1:0] RPM_DIVIDEND_RESET = 32'd37500000;
   localparam logic [WORD_W-1:0] FREQ_DIVIDEND_RESET = 32'd62500000;
   localparam logic [SHIFT_W-1:0] FREQ_SHIFT_RESET = 4'd4;
   localparam logic [WORD_W-1:0] RPM_LIMIT = 32'd65535;
   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   // Register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RPM_DIVIDEND = 2'd0,
      CSR_FREQ_DIVIDEND = 2'd1,
      CSR_FREQ_SHIFT = 2'd2
   } csr_index_type;

   // Channel codes
   localparam logic CH_FREQ = 1'b0;
   localparam logic CH_RPM = 1'b1;

   // Output payload: period_ticks, rate_value, rate_saturated, zero_divisor
   localparam int RSP_DATA_W = 56;

   // One classified capture, handed from front to back
   typedef struct packed {
      logic channel;
      logic [PERIOD_W-1:0] period_ticks;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_DIVIDE = 2'd1,
      BK_FINISH = 2'd2
   } back_state_type;

endpackage

// ===== hw/rtl/capture_period_rate_meter.sv =====
// Top level of the capture period rate meter.
//
// Each request transfer carries one timer capture stamp (tdata) tagged with
// its channel (tuser: 0 frequency, 1 rpm). The front end forms the wrapping
// period against that channel's previous stamp in the cycle it accepts the
// transfer and queues a divide job; the back end runs a one-bit-per-cycle
// restoring divider, so each item goes from job pop through 32 divide steps
// to the result load, or from pop straight to the result load on a zero
// divisor. The shared divider pops the next job only after that load. A
// two-entry job queue and the result register let the front keep taking
// captures while a result waits to be taken.
// Channel 1 reports rpm_dividend / period clamped to 65535 (rate_saturated
// set); channel 0 reports freq_dividend / (period >> freq_shift). A zero
// divisor gives all ones with zero_divisor set. Both previous stamps reset
// to zero. Write the csr registers only while the block is idle.
module capture_period_rate_meter #(
   parameter int TIMER_BITS = cpm_pkg::TIMER_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = cpm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [cpm_pkg::STAMP_W-1:0] req_tdata,       // [15:0] capture_time
   input  logic req_tuser,                              // [0] channel
   // result channel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [15:0] period_ticks, [47:16] rate_value, [48] rate_saturated,
   // [49] zero_divisor, [55:50] zero
   output logic [cpm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic rsp_tuser,                              // [0] source_channel
   // configuration writes
   input  logic csr_we,
   input  logic [cpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cpm_pkg::WORD_W-1:0] csr_wdata
);
   import cpm_pkg::*;

   logic [WORD_W-1:0] rpm_dividend_ff;
   logic [WORD_W-1:0] freq_dividend_ff;
   logic [SHIFT_W-1:0] freq_shift_ff;

   job_type push_job, pop_job;
   logic job_push, job_full, job_valid, job_pop;

   // csr registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         rpm_dividend_ff <= RPM_DIVIDEND_RESET;
         freq_dividend_ff <= FREQ_DIVIDEND_RESET;
         freq_shift_ff <= FREQ_SHIFT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RPM_DIVIDEND: rpm_dividend_ff <= csr_wdata;
            CSR_FREQ_DIVIDEND: freq_dividend_ff <= csr_wdata;
            CSR_FREQ_SHIFT: freq_shift_ff <= csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   cpm_front #(
      .TIMER_BITS(TIMER_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rpm_dividend(rpm_dividend_ff),
      .freq_dividend(freq_dividend_ff),
      .freq_shift(freq_shift_ff),
      .job_full(job_full),
      .job_push(job_push),
      .job(push_job)
   );

   cpm_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_job(push_job),
      .full(job_full),
      .pop(job_pop),
      .valid(job_valid),
      .pop_job(pop_job)
   );

   cpm_back u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(job_valid),
      .job(pop_job),
      .job_pop(job_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

endmodule

// ===== hw/rtl/cpm_front.sv =====
// Front end: takes capture stamps, forms the period and the divide job.
module cpm_front #(
   parameter int TIMER_BITS = cpm_pkg::TIMER_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [cpm_pkg::STAMP_W-1:0] req_tdata,
   input  logic req_tuser,
   input  logic [cpm_pkg::WORD_W-1:0] rpm_dividend,
   input  logic [cpm_pkg::WORD_W-1:0] freq_dividend,
   input  logic [cpm_pkg::SHIFT_W-1:0] freq_shift,
   input  logic job_full,
   output logic job_push,
   output cpm_pkg::job_type job
);
   import cpm_pkg::*;

   logic [TIMER_BITS-1:0] prev_ff [2];
   logic [TIMER_BITS-1:0] stamp;
   logic [TIMER_BITS-1:0] period;
   logic [WORD_W-1:0] period_ext;
   logic [PERIOD_W-1:0] period_low;

   generate
      if (TIMER_BITS >= STAMP_W) begin : g_stamp_wide
         assign stamp = TIMER_BITS'(req_tdata);
      end else begin : g_stamp_narrow
         assign stamp = req_tdata[TIMER_BITS-1:0];
      end
      if (TIMER_BITS >= PERIOD_W) begin : g_period_wide
         assign period_low = period[PERIOD_W-1:0];
      end else begin : g_period_narrow
         assign period_low = PERIOD_W'(period);
      end
      if (TIMER_BITS >= WORD_W) begin : g_ext_full
         assign period_ext = period[WORD_W-1:0];
      end else begin : g_ext_pad
         assign period_ext = WORD_W'(period);
      end
   endgenerate

   assign period = stamp - prev_ff[req_tuser];
   assign req_tready = !job_full;
   assign job_push = req_tvalid && !job_full;

   always_comb begin
      job.channel = req_tuser;
      job.period_ticks = period_low;
      if (req_tuser == CH_RPM) begin
         job.dividend = rpm_dividend;
         job.divisor = period_ext;
      end else begin
         job.dividend = freq_dividend;
         job.divisor = period_ext >> freq_shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff[0] <= '0;
         prev_ff[1] <= '0;
      end else if (job_push) begin
         prev_ff[req_tuser] <= stamp;
      end
   end

endmodule

// ===== hw/rtl/cpm_queue.sv =====
// Small job queue between front and back.
module cpm_queue #(
   parameter int DEPTH = cpm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  cpm_pkg::job_type push_job,
   output logic full,
   input  logic pop,
   output logic valid,
   output cpm_pkg::job_type pop_job
);
   import cpm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == FULL_COUNT);
   assign valid = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop = pop && valid;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/cpm_back.sv =====
// Back end: radix-2 restoring divider, clamp and result register.
module cpm_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   input  cpm_pkg::job_type job,
   output logic job_pop,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [cpm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic rsp_tuser
);
   import cpm_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);

   back_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff;
   logic [WORD_W-1:0] dq_ff;      // dividend out at top, quotient in at bottom
   logic [WORD_W-1:0] rem_ff;
   logic [WORD_W-1:0] divisor_ff;
   logic channel_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic zero_ff;

   logic out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic out_user_ff;

   logic out_free, load_job, div_step, load_out;
   logic [WORD_W:0] trial, diff;
   logic [WORD_W-1:0] rate;
   logic sat;

   assign out_free = !out_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               state_in = (job.divisor == '0) ? BK_FINISH : BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (count_ff == '0) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      load_job = 1'b0;
      div_step = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE: load_job = job_valid;
         BK_DIVIDE: div_step = 1'b1;
         BK_FINISH: load_out = out_free;
         default: ;
      endcase
   end

   assign job_pop = load_job;

   assign trial = {rem_ff, dq_ff[WORD_W-1]};
   assign diff = trial - {1'b0, divisor_ff};

   always_comb begin
      rate = dq_ff;
      sat = 1'b0;
      if (zero_ff) begin
         rate = ALL_ONES;
      end else if (channel_ff == CH_RPM && dq_ff > RPM_LIMIT) begin
         rate = RPM_LIMIT;
         sat = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_job) begin
         dq_ff <= job.dividend;
         rem_ff <= '0;
         divisor_ff <= job.divisor;
         channel_ff <= job.channel;
         period_ff <= job.period_ticks;
         zero_ff <= (job.divisor == '0);
         count_ff <= CNT_W'(WORD_W - 1);
      end else if (div_step) begin
         if (!diff[WORD_W]) begin
            rem_ff <= diff[WORD_W-1:0];
            dq_ff <= {dq_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[WORD_W-1:0];
            dq_ff <= {dq_ff[WORD_W-2:0], 1'b0};
         end
         count_ff <= count_ff - 1'b1;
      end
      if (load_out) begin
         out_data_ff <= {6'b0, zero_ff, sat, rate, period_ff};
         out_user_ff <= channel_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_user_ff;

endmodule
